@@ src/lmps_pkg.sv @@
// shared package of the led matrix pwm scanner
// holds default sizes, stream field widths, opcodes, sequencer states and memory control
// no dependencies
package lmps_pkg;

  // default matrix and pwm sizes
  localparam int DEF_ROWS        = 8;
  localparam int DEF_COLUMNS     = 8;
  localparam int DEF_PHASE_STEPS = 16;

  // input item fields
  localparam int IN_COL_W   = 3;
  localparam int IN_ROW_W   = 3;
  localparam int IN_LVL_W   = 8;
  localparam int IN_TDATA_W = 16;

  // result item fields
  localparam int OUT_ROW_W   = 4;
  localparam int OUT_MASK_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // opcodes carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY
  } lmps_state_e;

  // strobes from the sequencer to the level tables
  typedef struct packed {
    logic pend_wr;
    logic pend_rd;
    logic disp_rd;
    logic disp_wr;
  } lmps_mem_ctl_t;

endpackage

@@ src/led_matrix_pwm_scanner.sv @@
// pwm scanner for an led matrix with double buffered per-led levels
// an in-range write item enters the pending table when accepted; a tick passes the state
// register, the registered table read and the result register before its first row result,
// then one row per cycle while the output is taken; ready stays low through the row scan
// (one registered table read per row) and the row-by-row table copy when the phase wraps to zero
// reset: tables read as zero through valid bits and phase is zero; ready right after reset
module led_matrix_pwm_scanner #(
  parameter int ROWS        = lmps_pkg::DEF_ROWS,
  parameter int COLUMNS     = lmps_pkg::DEF_COLUMNS,
  parameter int PHASE_STEPS = lmps_pkg::DEF_PHASE_STEPS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // column [2:0], row [5:3], level [13:6], zero fill [15:14]
  input  logic [lmps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // row_number [3:0], column_mask [11:4], zero fill [15:12]
  output logic [lmps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import lmps_pkg::*;

  localparam int LW     = $clog2(PHASE_STEPS + 1);
  localparam int PW     = $clog2(PHASE_STEPS);
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [IN_COL_W-1:0]   in_col;
  logic [IN_ROW_W-1:0]   in_row;
  logic [IN_LVL_W-1:0]   in_level;
  lmps_mem_ctl_t         mem_ctl;
  logic [ROW_AW-1:0]     rd_row;
  logic [ROW_AW-1:0]     disp_wr_row;
  logic [COLUMNS*LW-1:0] disp_row;
  logic [PW-1:0]         phase;
  logic [OUT_MASK_W-1:0] mask;
  logic [OUT_ROW_W-1:0]  out_row;
  logic [OUT_MASK_W-1:0] out_mask;

  // input item fields
  assign in_col   = s_axis_tdata[IN_COL_W-1:0];
  assign in_row   = s_axis_tdata[IN_COL_W +: IN_ROW_W];
  assign in_level = s_axis_tdata[IN_COL_W+IN_ROW_W +: IN_LVL_W];

  lmps_ctrl #(
    .ROWS        (ROWS),
    .COLUMNS     (COLUMNS),
    .PHASE_STEPS (PHASE_STEPS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .wr_row_i      (in_row),
    .wr_col_i      (in_col),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_row_o       (out_row),
    .m_mask_o      (out_mask),
    .m_last_o      (m_axis_tlast),
    .mask_i        (mask),
    .phase_o       (phase),
    .mem_ctl_o     (mem_ctl),
    .rd_row_o      (rd_row),
    .disp_wr_row_o (disp_wr_row)
  );

  lmps_level_store #(
    .ROWS        (ROWS),
    .COLUMNS     (COLUMNS),
    .PHASE_STEPS (PHASE_STEPS)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mem_ctl_i     (mem_ctl),
    .rd_row_i      (rd_row),
    .disp_wr_row_i (disp_wr_row),
    .pw_row_i      (in_row),
    .pw_col_i      (in_col),
    .pw_level_i    (in_level),
    .disp_row_o    (disp_row)
  );

  lmps_row_cmp #(
    .COLUMNS     (COLUMNS),
    .PHASE_STEPS (PHASE_STEPS)
  ) u_cmp (
    .levels_i (disp_row),
    .phase_i  (phase),
    .mask_o   (mask)
  );

  // result item packing
  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_ROW_W-OUT_MASK_W){1'b0}}, out_mask, out_row};

endmodule

@@ src/lmps_row_cmp.sv @@
// shared row compare unit: one row of displayed levels against the pwm phase
// depends on lmps_pkg
module lmps_row_cmp #(
  parameter int COLUMNS     = lmps_pkg::DEF_COLUMNS,
  parameter int PHASE_STEPS = lmps_pkg::DEF_PHASE_STEPS
) (
  input  logic [COLUMNS*$clog2(PHASE_STEPS+1)-1:0] levels_i,
  input  logic [$clog2(PHASE_STEPS)-1:0]           phase_i,
  output logic [lmps_pkg::OUT_MASK_W-1:0]          mask_o
);
  import lmps_pkg::*;

  localparam int LW     = $clog2(PHASE_STEPS + 1);
  localparam int MASK_N = (COLUMNS < OUT_MASK_W) ? COLUMNS : OUT_MASK_W;

  logic [COLUMNS-1:0] hit;

  // one comparator per column, columns past the mask width are dropped
  always_comb begin
    hit = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      hit[c] = levels_i[c*LW +: LW] > LW'(phase_i);
    end
  end

  assign mask_o = OUT_MASK_W'(hit[MASK_N-1:0]);

endmodule

@@ src/lmps_level_store.sv @@
// pending and displayed level tables, one row word per matrix row
// depends on lmps_pkg; strobes and addresses come from lmps_ctrl
module lmps_level_store #(
  parameter int ROWS        = lmps_pkg::DEF_ROWS,
  parameter int COLUMNS     = lmps_pkg::DEF_COLUMNS,
  parameter int PHASE_STEPS = lmps_pkg::DEF_PHASE_STEPS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  lmps_pkg::lmps_mem_ctl_t                  mem_ctl_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row_i,
  input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] disp_wr_row_i,
  input  logic [lmps_pkg::IN_ROW_W-1:0]            pw_row_i,
  input  logic [lmps_pkg::IN_COL_W-1:0]            pw_col_i,
  input  logic [lmps_pkg::IN_LVL_W-1:0]            pw_level_i,
  output logic [COLUMNS*$clog2(PHASE_STEPS+1)-1:0] disp_row_o
);
  import lmps_pkg::*;

  localparam int LW     = $clog2(PHASE_STEPS + 1);
  localparam int RW     = COLUMNS * LW;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [RW-1:0]      pend_mem [ROWS];
  logic [RW-1:0]      disp_mem [ROWS];
  logic [COLUMNS-1:0] pend_vld_q [ROWS];
  logic [ROWS-1:0]    disp_vld_q;

  logic [RW-1:0]      pend_rdata_q;
  logic [COLUMNS-1:0] pend_rvld_q;
  logic [RW-1:0]      disp_rdata_q;
  logic               disp_rvld_q;

  logic [ROW_AW-1:0]  pw_row;
  logic [COL_AW-1:0]  pw_col;
  logic [IN_LVL_W:0]  lvl_ext;
  logic [LW-1:0]      lvl_sat;
  logic [RW-1:0]      pend_row;

  assign pw_row  = ROW_AW'(pw_row_i);
  assign pw_col  = COL_AW'(pw_col_i);

  // saturate the written level to the always-on level
  assign lvl_ext = {1'b0, pw_level_i};
  assign lvl_sat = (lvl_ext > (IN_LVL_W+1)'(PHASE_STEPS)) ? LW'(PHASE_STEPS) : LW'(lvl_ext);

  // valid bits stand in for the cleared tables after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        pend_vld_q[r] <= '0;
      end
      disp_vld_q <= '0;
    end else begin
      if (mem_ctl_i.pend_wr) begin
        for (int c = 0; c < COLUMNS; c++) begin
          if (pw_col == COL_AW'(c)) begin
            pend_vld_q[pw_row][c] <= 1'b1;
          end
        end
      end
      if (mem_ctl_i.disp_wr) begin
        disp_vld_q[disp_wr_row_i] <= 1'b1;
      end
    end
  end

  // pending table: column lane write, registered row read
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.pend_wr) begin
      for (int c = 0; c < COLUMNS; c++) begin
        if (pw_col == COL_AW'(c)) begin
          pend_mem[pw_row][c*LW +: LW] <= lvl_sat;
        end
      end
    end
    if (mem_ctl_i.pend_rd) begin
      pend_rdata_q <= pend_mem[rd_row_i];
      pend_rvld_q  <= pend_vld_q[rd_row_i];
    end
  end

  // lanes never written read as zero
  always_comb begin
    for (int c = 0; c < COLUMNS; c++) begin
      pend_row[c*LW +: LW] = pend_rvld_q[c] ? pend_rdata_q[c*LW +: LW] : '0;
    end
  end

  // displayed table: whole row write from the copy sweep, registered row read
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.disp_wr) begin
      disp_mem[disp_wr_row_i] <= pend_row;
    end
    if (mem_ctl_i.disp_rd) begin
      disp_rdata_q <= disp_mem[rd_row_i];
      disp_rvld_q  <= disp_vld_q[rd_row_i];
    end
  end

  assign disp_row_o = disp_rvld_q ? disp_rdata_q : '0;

endmodule

@@ src/lmps_ctrl.sv @@
// sequencer: takes items, walks the rows through the compare unit, runs the copy sweep
// holds the pwm phase and the result register; depends on lmps_pkg
module lmps_ctrl #(
  parameter int ROWS        = lmps_pkg::DEF_ROWS,
  parameter int COLUMNS     = lmps_pkg::DEF_COLUMNS,
  parameter int PHASE_STEPS = lmps_pkg::DEF_PHASE_STEPS
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_valid_i,
  output logic                                       s_ready_o,
  input  logic                                       opcode_i,
  input  logic [lmps_pkg::IN_ROW_W-1:0]              wr_row_i,
  input  logic [lmps_pkg::IN_COL_W-1:0]              wr_col_i,
  output logic                                       m_valid_o,
  input  logic                                       m_ready_i,
  output logic [lmps_pkg::OUT_ROW_W-1:0]             m_row_o,
  output logic [lmps_pkg::OUT_MASK_W-1:0]            m_mask_o,
  output logic                                       m_last_o,
  input  logic [lmps_pkg::OUT_MASK_W-1:0]            mask_i,
  output logic [$clog2(PHASE_STEPS)-1:0]             phase_o,
  output lmps_pkg::lmps_mem_ctl_t                    mem_ctl_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] disp_wr_row_o
);
  import lmps_pkg::*;

  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW     = $clog2(PHASE_STEPS);
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
  localparam logic [PW-1:0]     PH_LAST  = PW'(PHASE_STEPS - 1);

  lmps_state_e state_q, state_d;

  logic [PW-1:0]     phase_q, phase_d;
  logic [ROW_AW-1:0] iss_row_q, iss_row_d;
  logic              iss_done_q, iss_done_d;
  logic              fly_q, fly_d;
  logic [ROW_AW-1:0] fly_row_q, fly_row_d;
  logic              out_vld_q, out_vld_d;
  logic [OUT_ROW_W-1:0]  out_row_q;
  logic [OUT_MASK_W-1:0] out_mask_q;
  logic              out_last_q;

  logic              in_acc, in_range, tick, wrap;
  logic              adv, issue, consume, load_out, scan_end, copy_end, restart;
  logic [ROW_AW:0]   row_num;

  assign in_acc   = s_valid_i && s_ready_o;
  assign in_range = (5'(wr_row_i) < 5'(ROWS)) && (5'(wr_col_i) < 5'(COLUMNS));
  assign tick     = in_acc && (opcode_i == OP_TICK);
  assign wrap     = (phase_q == PH_LAST);
  assign adv      = fly_q && (!out_vld_q || m_ready_i);

  // state outputs and strobes
  always_comb begin
    s_ready_o = 1'b0;
    mem_ctl_o = '0;
    issue     = 1'b0;
    consume   = 1'b0;
    load_out  = 1'b0;
    scan_end  = 1'b0;
    copy_end  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o         = 1'b1;
        mem_ctl_o.pend_wr = s_valid_i && (opcode_i == OP_WRITE) && in_range;
      end
      ST_SCAN: begin
        issue             = !iss_done_q && (!fly_q || adv);
        mem_ctl_o.disp_rd = issue;
        consume           = adv;
        load_out          = adv;
        scan_end          = adv && (fly_row_q == ROW_LAST);
      end
      ST_COPY: begin
        issue             = !iss_done_q;
        mem_ctl_o.pend_rd = issue;
        mem_ctl_o.disp_wr = fly_q;
        consume           = fly_q;
        copy_end          = fly_q && (fly_row_q == ROW_LAST);
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (tick) state_d = ST_SCAN;
      ST_SCAN: if (scan_end) state_d = wrap ? ST_COPY : ST_IDLE;
      ST_COPY: if (copy_end) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // row walk, phase and result register updates
  assign restart = tick || (scan_end && wrap);

  always_comb begin
    iss_row_d  = iss_row_q;
    iss_done_d = iss_done_q;
    if (restart) begin
      iss_row_d  = '0;
      iss_done_d = 1'b0;
    end else if (issue) begin
      iss_row_d  = iss_row_q + 1'b1;
      iss_done_d = (iss_row_q == ROW_LAST);
    end
    fly_d     = issue ? 1'b1 : (consume ? 1'b0 : fly_q);
    fly_row_d = issue ? iss_row_q : fly_row_q;
    phase_d   = scan_end ? (wrap ? '0 : phase_q + 1'b1) : phase_q;
    out_vld_d = load_out ? 1'b1 : (m_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= '0;
      iss_row_q  <= '0;
      iss_done_q <= 1'b1;
      fly_q      <= 1'b0;
      fly_row_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      iss_row_q  <= iss_row_d;
      iss_done_q <= iss_done_d;
      fly_q      <= fly_d;
      fly_row_q  <= fly_row_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // result payload, row number is index plus one
  assign row_num = {1'b0, fly_row_q} + (ROW_AW+1)'(1);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q  <= OUT_ROW_W'(row_num);
      out_mask_q <= mask_i;
      out_last_q <= (fly_row_q == ROW_LAST);
    end
  end

  assign m_valid_o     = out_vld_q;
  assign m_row_o       = out_row_q;
  assign m_mask_o      = out_mask_q;
  assign m_last_o      = out_last_q;
  assign phase_o       = phase_q;
  assign rd_row_o      = iss_row_q;
  assign disp_wr_row_o = fly_row_q;

  // phase only moves at the end of a row scan
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |=> $stable(phase_q))
    else $error("phase changed outside a scan");

  // the copy sweep starts only once the phase has wrapped
  a_copy_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && $past(state_q) != ST_COPY) |-> (phase_q == '0))
    else $error("copy sweep started without phase wrap");

  // no row read is left in flight when idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !fly_q)
    else $error("row read in flight while idle");

  // the final row result carries the last row number
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |-> (out_row_q == OUT_ROW_W'(ROWS)))
    else $error("last flag on a wrong row");

endmodule
